// ----- hw/rtl/aks_pkg.sv -----
// Shared types and constants of the animation keyframe sampler.
package aks_pkg;

  typedef enum logic [1:0] {
    MODE_CLAMP  = 2'd0,
    MODE_WRAP   = 2'd1,
    MODE_MIRROR = 2'd2,
    MODE_NONE   = 2'd3
  } aks_mode_e;

  localparam int unsigned QUOT_BITS = 17;
  localparam logic [16:0] BLEND_ONE = 17'h1_0000;
  localparam logic [15:0] BLEND_MAX = 16'hFFFF;

  typedef struct packed {
    logic        neg;
    logic        tzero;
    logic [15:0] frames;
    aks_mode_e   mode;
    logic [15:0] qs;
  } aks_ctl_t;

  typedef struct packed {
    logic [15:0] frame_now;
    logic [15:0] frame_after;
    logic        updated;
    logic [16:0] blend;
    logic [15:0] qs;
  } aks_quant_t;

endpackage

// ----- hw/rtl/aks_norm.sv -----
// Timeline normalization: magnitude product, rounding shift and saturation.
module aks_norm import aks_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  logic signed [31:0] time_line_i,
  input  logic        [31:0] duration_scale_i,
  input  logic        [15:0] frame_total_i,
  input  logic        [1:0]  play_mode_i,
  input  logic        [15:0] quant_steps_i,
  output logic               valid_o,
  output aks_ctl_t           ctl_o,
  output logic        [31:0] qsat_o
);

  localparam int unsigned NORM_SHIFT = 32 - FRAC_BITS;
  localparam logic [63:0] LOW_MASK = (64'd1 << NORM_SHIFT) - 64'd1;

  logic        [31:0] tl_u;
  logic        [31:0] mag;
  logic        [63:0] prod_d;
  aks_ctl_t           ctl_d;
  logic               v1_q;
  aks_ctl_t           ctl1_q;
  logic        [63:0] prod_q;
  logic        [63:0] qhi;
  logic        [63:0] qrnd;
  logic        [31:0] qsat_d;
  logic               v2_q;
  aks_ctl_t           ctl2_q;
  logic        [31:0] qsat_q;

  always_comb begin
    tl_u         = $unsigned(time_line_i);
    ctl_d.neg    = tl_u[31];
    ctl_d.tzero  = (tl_u == 32'd0);
    ctl_d.frames = frame_total_i;
    ctl_d.mode   = aks_mode_e'(play_mode_i);
    ctl_d.qs     = quant_steps_i;
    mag          = tl_u[31] ? (32'd0 - tl_u) : tl_u;
    prod_d       = 64'(mag) * 64'(duration_scale_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    ctl1_q <= ctl_d;
    prod_q <= prod_d;
  end

  always_comb begin
    qhi  = prod_q >> NORM_SHIFT;
    qrnd = qhi + 64'(|(prod_q & LOW_MASK));
    if (!ctl1_q.neg) begin
      qsat_d = (qhi > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : qhi[31:0];
    end else begin
      qsat_d = (qrnd > 64'h8000_0000) ? 32'h8000_0000 : qrnd[31:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    ctl2_q <= ctl1_q;
    qsat_q <= qsat_d;
  end

  assign valid_o = v2_q;
  assign ctl_o   = ctl2_q;
  assign qsat_o  = qsat_q;

endmodule

// ----- hw/rtl/aks_frame.sv -----
// Keyframe position, play mode selection and quantizer product.
module aks_frame import aks_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  input  aks_ctl_t    ctl_i,
  input  logic [31:0] qsat_i,
  output logic        valid_o,
  output aks_quant_t  quant_o,
  output logic [15:0] k_o
);

  localparam int unsigned PW = FRAC_BITS + 16;

  logic [31:0]          qneg;
  logic [FRAC_BITS-1:0] fr;
  logic [15:0]          span3;
  logic [PW-1:0]        p_d;
  logic                 v3_q;
  aks_ctl_t             ctl3_q;
  logic [PW-1:0]        p3_q;
  logic                 odd3_q;
  logic                 hi3_q;
  logic [15:0]          key;
  logic [FRAC_BITS-1:0] pfrac;
  logic [23:0]          w24;
  logic [15:0]          lerp;
  logic [15:0]          span4;
  aks_quant_t           quant_d;
  logic                 v4_q;
  aks_quant_t           q4_q;
  logic [31:0]          bq;
  logic                 v5_q;
  aks_quant_t           q5_q;
  logic [15:0]          k5_q;

  always_comb begin
    qneg  = 32'd0 - qsat_i;
    fr    = ctl_i.neg ? qneg[FRAC_BITS-1:0] : qsat_i[FRAC_BITS-1:0];
    span3 = ctl_i.frames - 16'd1;
    p_d   = PW'(fr) * PW'(span3);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else begin
      v3_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    ctl3_q <= ctl_i;
    p3_q   <= p_d;
    odd3_q <= qsat_i[FRAC_BITS];
    hi3_q  <= !ctl_i.neg && (|qsat_i[31:FRAC_BITS]);
  end

  always_comb begin
    key     = p3_q[PW-1:FRAC_BITS];
    pfrac   = p3_q[FRAC_BITS-1:0];
    w24     = 24'(pfrac) << (24 - FRAC_BITS);
    lerp    = w24[23:8];
    span4   = ctl3_q.frames - 16'd1;
    quant_d = '0;
    quant_d.qs = ctl3_q.qs;
    if (ctl3_q.frames == 16'd0 || ctl3_q.mode == MODE_NONE) begin
      quant_d.updated = 1'b0;
    end else if (ctl3_q.frames == 16'd1) begin
      quant_d.updated = 1'b1;
    end else begin
      quant_d.updated = 1'b1;
      case (ctl3_q.mode) inside
        MODE_CLAMP: begin
          if (ctl3_q.neg || ctl3_q.tzero) begin
            quant_d.frame_now   = 16'd0;
            quant_d.frame_after = 16'd0;
          end else if (hi3_q) begin
            quant_d.frame_now   = span4;
            quant_d.frame_after = span4;
          end else begin
            quant_d.frame_now   = key;
            quant_d.frame_after = key + 16'd1;
            quant_d.blend       = 17'(lerp);
          end
        end
        MODE_WRAP, MODE_MIRROR: begin
          if (ctl3_q.neg) begin
            quant_d.frame_now   = key + 16'd1;
            quant_d.frame_after = key;
            quant_d.blend       = BLEND_ONE - 17'(lerp);
          end else begin
            quant_d.frame_now   = key;
            quant_d.frame_after = key + 16'd1;
            quant_d.blend       = 17'(lerp);
          end
          if (ctl3_q.mode == MODE_MIRROR && odd3_q) begin
            quant_d.frame_now   = span4 - quant_d.frame_now;
            quant_d.frame_after = span4 - quant_d.frame_after;
          end
        end
        default: begin
          quant_d.updated = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else begin
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    q4_q <= quant_d;
  end

  assign bq = 32'(q4_q.blend) * 32'(q4_q.qs);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
    end else begin
      v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    q5_q <= q4_q;
    k5_q <= bq[31:16];
  end

  assign valid_o = v5_q;
  assign quant_o = q5_q;
  assign k_o     = k5_q;

endmodule

// ----- hw/rtl/aks_div.sv -----
// Pipelined restoring divider for the blend quantizer, one quotient bit per stage.
module aks_div import aks_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  input  aks_quant_t           quant_i,
  input  logic [15:0]          k_i,
  output logic                 valid_o,
  output aks_quant_t           quant_o,
  output logic [QUOT_BITS-1:0] quot_o
);

  logic                 valid_q [QUOT_BITS];
  aks_quant_t           pay_q   [QUOT_BITS];
  logic [15:0]          rem_q   [QUOT_BITS];
  logic [QUOT_BITS-1:0] quot_q  [QUOT_BITS];

  for (genvar s = 0; s < QUOT_BITS; s++) begin : g_stage
    logic                 v_in;
    aks_quant_t           pay_in;
    logic [15:0]          rem_in;
    logic [QUOT_BITS-1:0] quot_in;
    logic                 nbit;
    logic [16:0]          rem2;
    logic                 ge;
    logic [16:0]          diff;
    logic [15:0]          rem_d;

    if (s == 0) begin : g_first
      assign v_in    = valid_i;
      assign pay_in  = quant_i;
      assign rem_in  = {1'b0, k_i[15:1]};
      assign quot_in = '0;
      assign nbit    = k_i[0];
    end else begin : g_next
      assign v_in    = valid_q[s-1];
      assign pay_in  = pay_q[s-1];
      assign rem_in  = rem_q[s-1];
      assign quot_in = quot_q[s-1];
      assign nbit    = 1'b0;
    end

    always_comb begin
      rem2  = {rem_in, nbit};
      ge    = rem2 >= {1'b0, pay_in.qs};
      diff  = rem2 - {1'b0, pay_in.qs};
      rem_d = ge ? diff[15:0] : rem2[15:0];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[s] <= 1'b0;
      end else begin
        valid_q[s] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      pay_q[s]  <= pay_in;
      rem_q[s]  <= rem_d;
      quot_q[s] <= {quot_in[QUOT_BITS-2:0], ge};
    end
  end

  assign valid_o = valid_q[QUOT_BITS-1];
  assign quant_o = pay_q[QUOT_BITS-1];
  assign quot_o  = quot_q[QUOT_BITS-1];

endmodule

// ----- hw/rtl/animation_keyframe_sampler_top.sv -----
// Top level of the animation keyframe sampler.
//
// One controller is transferred in at each rising edge where start is high and
// busy is low. busy stays low, so a controller may be issued every cycle.
// Fields: time_line_i (signed Q15.16), duration_scale_i (Q16.16 reciprocal of
// the duration), frame_total_i, play_mode_i, quant_steps_i.
// Each result appears for exactly one cycle with done_o high: frame_now_o,
// frame_after_o, blend_amount_o (Q0.16) and updated_o. Results leave in the
// order the controllers came in, one per controller.
// From the accepting edge to the edge that ends the done_o cycle, a controller
// passes the normalizing product registers, the keyframe position, play mode and
// quantizer product registers, the quantizer divider, one bit per stage, and
// the output register. Throughput is one controller per cycle.
// Reset clears every stage valid bit; no result is produced until new input.
// The receiver cannot stall: results are presented once and never held.
module animation_keyframe_sampler_top import aks_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] time_line_i,
  input  logic        [31:0] duration_scale_i,
  input  logic        [15:0] frame_total_i,
  input  logic        [1:0]  play_mode_i,
  input  logic        [15:0] quant_steps_i,
  output logic               done_o,
  output logic        [15:0] frame_now_o,
  output logic        [15:0] frame_after_o,
  output logic        [15:0] blend_amount_o,
  output logic               updated_o
);

  logic                 norm_valid;
  aks_ctl_t             norm_ctl;
  logic [31:0]          norm_qsat;
  logic                 frm_valid;
  aks_quant_t           frm_quant;
  logic [15:0]          frm_k;
  logic                 div_valid;
  aks_quant_t           div_quant;
  logic [QUOT_BITS-1:0] div_quot;
  logic [16:0]          blend_raw;
  logic [15:0]          blend_d;
  logic                 done_q;
  logic [15:0]          frame_now_q;
  logic [15:0]          frame_after_q;
  logic [15:0]          blend_q;
  logic                 updated_q;

  assign busy = 1'b0;

  aks_norm #(
    .FRAC_BITS(FRAC_BITS)
  ) u_norm (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .valid_i         (start && !busy),
    .time_line_i     (time_line_i),
    .duration_scale_i(duration_scale_i),
    .frame_total_i   (frame_total_i),
    .play_mode_i     (play_mode_i),
    .quant_steps_i   (quant_steps_i),
    .valid_o         (norm_valid),
    .ctl_o           (norm_ctl),
    .qsat_o          (norm_qsat)
  );

  aks_frame #(
    .FRAC_BITS(FRAC_BITS)
  ) u_frame (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(norm_valid),
    .ctl_i  (norm_ctl),
    .qsat_i (norm_qsat),
    .valid_o(frm_valid),
    .quant_o(frm_quant),
    .k_o    (frm_k)
  );

  aks_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(frm_valid),
    .quant_i(frm_quant),
    .k_i    (frm_k),
    .valid_o(div_valid),
    .quant_o(div_quant),
    .quot_o (div_quot)
  );

  always_comb begin
    blend_raw = (div_quant.qs == 16'd0) ? div_quant.blend : div_quot;
    blend_d   = (blend_raw > 17'(BLEND_MAX)) ? BLEND_MAX : blend_raw[15:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= div_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    frame_now_q   <= div_quant.frame_now;
    frame_after_q <= div_quant.frame_after;
    blend_q       <= blend_d;
    updated_q     <= div_quant.updated;
  end

  assign done_o         = done_q;
  assign frame_now_o    = frame_now_q;
  assign frame_after_o  = frame_after_q;
  assign blend_amount_o = blend_q;
  assign updated_o      = updated_q;

endmodule

// ----- bench/animation_keyframe_sampler_top_test.sv -----
// Sampler testbench: directed and random controllers checked against a local predictor.
`timescale 1ns / 1ps

module animation_keyframe_sampler_top_test;
  import aks_pkg::*;

  localparam int unsigned QUIET_LIMIT = 2000;
  localparam int unsigned DRAIN_CYCLES = 30;
  localparam int unsigned RANDOM_ITEMS = 730;
  localparam int unsigned PRINT_CAP = 50;

  typedef struct packed {
    logic signed [31:0] time_line;
    logic        [31:0] duration_scale;
    logic        [15:0] frame_total;
    aks_mode_e          play_mode;
    logic        [15:0] quant_steps;
  } ctrl_t;

  typedef struct packed {
    logic [15:0] frame_now;
    logic [15:0] frame_after;
    logic [15:0] blend_amount;
    logic        updated;
  } pose_t;

  class pose_ledger;
    pose_t poses_due[$];
    int    mismatches;
    int    checked;
    int    mode_seen[4];

    function new();
      mismatches = 0;
      checked = 0;
      foreach (mode_seen[i]) mode_seen[i] = 0;
    endfunction

    function logic [31:0] quantize(logic [31:0] b, logic [15:0] steps);
      longint unsigned k;
      longint unsigned s;
      if (steps == 16'd0) return b;
      s = {48'd0, steps};
      k = ({32'd0, b} * s) >> 16;
      return 32'((k << 16) / s);
    endfunction

    function logic [15:0] clip_blend(logic [31:0] b);
      return (b > 32'h0000_FFFF) ? BLEND_MAX : b[15:0];
    endfunction

    function pose_t sample_pose(ctrl_t c);
      logic              neg;
      logic [31:0]       tmag;
      longint unsigned   prod;
      longint unsigned   norm_mag;
      longint unsigned   span;
      longint unsigned   pos;
      longint unsigned   frac;
      logic [31:0]       key_idx;
      logic [31:0]       lerp;
      logic [31:0]       f_now;
      logic [31:0]       f_after;
      pose_t             r;
      r = '0;
      if (c.play_mode == MODE_NONE || c.frame_total == 16'd0) return r;
      r.updated = 1'b1;
      if (c.frame_total == 16'd1) return r;
      neg = c.time_line[31];
      tmag = neg ? (~c.time_line + 32'd1) : c.time_line;
      prod = {32'd0, tmag} * {32'd0, c.duration_scale};
      if (!neg) begin
        norm_mag = prod >> 16;
        if (norm_mag > 64'h7FFF_FFFF) norm_mag = 64'h7FFF_FFFF;
      end else begin
        norm_mag = (prod + 64'hFFFF) >> 16;
        if (norm_mag > 64'h8000_0000) norm_mag = 64'h8000_0000;
      end
      span = {48'd0, c.frame_total} - 64'd1;
      if (c.play_mode == MODE_CLAMP) begin
        if (neg || c.time_line == 32'sd0) return r;
        if (norm_mag >= 64'h1_0000) begin
          r.frame_now = span[15:0];
          r.frame_after = span[15:0];
          return r;
        end
        pos = norm_mag * span;
        key_idx = 32'(pos >> 16);
        lerp = 32'(pos & 64'hFFFF);
        r.frame_now = key_idx[15:0];
        r.frame_after = 16'(key_idx + 32'd1);
        r.blend_amount = clip_blend(quantize(lerp, c.quant_steps));
        return r;
      end
      frac = neg ? ((64'd0 - norm_mag) & 64'hFFFF) : (norm_mag & 64'hFFFF);
      pos = frac * span;
      key_idx = 32'(pos >> 16);
      lerp = 32'(pos & 64'hFFFF);
      if (neg) begin
        f_now = key_idx + 32'd1;
        f_after = key_idx;
        r.blend_amount = clip_blend(quantize(32'h1_0000 - lerp, c.quant_steps));
      end else begin
        f_now = key_idx;
        f_after = key_idx + 32'd1;
        r.blend_amount = clip_blend(quantize(lerp, c.quant_steps));
      end
      if (c.play_mode == MODE_MIRROR && norm_mag[16]) begin
        f_now = {16'd0, c.frame_total} - f_now - 32'd1;
        f_after = {16'd0, c.frame_total} - f_after - 32'd1;
      end
      r.frame_now = f_now[15:0];
      r.frame_after = f_after[15:0];
      return r;
    endfunction

    task flag_mismatch(string what, logic [31:0] got, logic [31:0] want);
      mismatches++;
      if (mismatches <= PRINT_CAP)
        $display("[%0t] mismatch %0d: %s got %0h want %0h", $realtime, mismatches, what,
                 got, want);
    endtask

    function void log_transfer(ctrl_t c);
      mode_seen[c.play_mode]++;
      poses_due.push_back(sample_pose(c));
    endfunction

    task match_result(pose_t got);
      pose_t want;
      if (poses_due.size() == 0) begin
        flag_mismatch("result with none pending", 32'd0, 32'd0);
        return;
      end
      want = poses_due.pop_front();
      checked++;
      if (got.frame_now !== want.frame_now)
        flag_mismatch("frame_now", got.frame_now, want.frame_now);
      if (got.frame_after !== want.frame_after)
        flag_mismatch("frame_after", got.frame_after, want.frame_after);
      if (got.blend_amount !== want.blend_amount)
        flag_mismatch("blend_amount", got.blend_amount, want.blend_amount);
      if (got.updated !== want.updated)
        flag_mismatch("updated", got.updated, want.updated);
    endtask

    task close_out();
      while (poses_due.size() != 0) begin
        void'(poses_due.pop_front());
        flag_mismatch("result never arrived", 32'd0, 32'd0);
      end
    endtask

    function int pending();
      return poses_due.size();
    endfunction
  endclass

  logic               clk_i;
  logic               rst_ni = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic signed [31:0] time_line_i = '0;
  logic        [31:0] duration_scale_i = '0;
  logic        [15:0] frame_total_i = '0;
  logic        [1:0]  play_mode_i = '0;
  logic        [15:0] quant_steps_i = '0;
  logic               done_o;
  logic        [15:0] frame_now_o;
  logic        [15:0] frame_after_o;
  logic        [15:0] blend_amount_o;
  logic               updated_o;

  pose_ledger  ledger = new();
  bit          idle_on = 1'b1;
  int unsigned quiet_cycles = 0;

  animation_keyframe_sampler_top uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .time_line_i      (time_line_i),
    .duration_scale_i (duration_scale_i),
    .frame_total_i    (frame_total_i),
    .play_mode_i      (play_mode_i),
    .quant_steps_i    (quant_steps_i),
    .done_o           (done_o),
    .frame_now_o      (frame_now_o),
    .frame_after_o    (frame_after_o),
    .blend_amount_o   (blend_amount_o),
    .updated_o        (updated_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni && done_o)
      ledger.match_result('{frame_now: frame_now_o, frame_after: frame_after_o,
                            blend_amount: blend_amount_o, updated: updated_o});
  end

  always @(posedge clk_i) begin
    if ((start && !busy) || done_o) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout: no transfer for %0d cycles", quiet_cycles);
      $display("animation_keyframe_sampler_top_test: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_ctrl(input ctrl_t c);
    int gap;
    gap = 0;
    if (idle_on)
      while ($urandom_range(99) < 21) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    time_line_i <= c.time_line;
    duration_scale_i <= c.duration_scale;
    frame_total_i <= c.frame_total;
    play_mode_i <= c.play_mode;
    quant_steps_i <= c.quant_steps;
    do @(posedge clk_i); while (busy);
    ledger.log_transfer(c);
  endtask

  task automatic send_fields(input logic [31:0] tl, input logic [31:0] ds,
                             input logic [15:0] fr, input aks_mode_e md,
                             input logic [15:0] qs);
    ctrl_t c;
    c.time_line = tl;
    c.duration_scale = ds;
    c.frame_total = fr;
    c.play_mode = md;
    c.quant_steps = qs;
    send_ctrl(c);
  endtask

  function automatic ctrl_t random_ctrl();
    ctrl_t c;
    case ($urandom_range(9)) inside
      0: c.frame_total = 16'd0;
      1: c.frame_total = 16'd1;
      7, 8: c.frame_total = 16'($urandom_range(2, 1000));
      9: c.frame_total = 16'($urandom);
      default: c.frame_total = 16'($urandom_range(2, 16));
    endcase
    c.play_mode = ($urandom_range(15) == 0) ? MODE_NONE : aks_mode_e'($urandom_range(0, 2));
    if ($urandom_range(15) == 0) begin
      c.time_line = $urandom;
      c.duration_scale = $urandom;
    end else begin
      c.time_line = $urandom >> $urandom_range(0, 31);
      if ($urandom_range(1)) c.time_line = -c.time_line;
      c.duration_scale = $urandom >> $urandom_range(4, 31);
    end
    case ($urandom_range(3)) inside
      0, 1: c.quant_steps = 16'd0;
      2: c.quant_steps = 16'($urandom_range(1, 20));
      default: c.quant_steps = 16'($urandom);
    endcase
    return c;
  endfunction

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_fields(32'h0001_8000, 32'h0001_0000, 16'd0, MODE_WRAP, 16'd0);
    send_fields(32'h0001_8000, 32'h0001_0000, 16'd5, MODE_NONE, 16'd0);
    send_fields(32'h1234_5678, 32'h0001_0000, 16'd1, MODE_WRAP, 16'd7);
    send_fields(32'h0000_0000, 32'h0001_0000, 16'd9, MODE_CLAMP, 16'd0);
    send_fields(32'hFFFF_0000, 32'h0001_0000, 16'd9, MODE_CLAMP, 16'd0);
    send_fields(32'h0002_0000, 32'h0001_0000, 16'd9, MODE_CLAMP, 16'd0);
    send_fields(32'h0000_8000, 32'h0001_0000, 16'd5, MODE_CLAMP, 16'd0);
    send_fields(32'h0000_9123, 32'h0001_0000, 16'd5, MODE_CLAMP, 16'd3);
    send_fields(32'h0001_8000, 32'h0001_0000, 16'd4, MODE_WRAP, 16'd0);
    send_fields(32'hFFFF_0000, 32'h0001_0000, 16'd4, MODE_WRAP, 16'd0);
    send_fields(32'hFFFE_A000, 32'h0001_0000, 16'd4, MODE_WRAP, 16'd0);
    send_fields(32'h0001_8000, 32'h0001_0000, 16'd6, MODE_MIRROR, 16'd0);
    send_fields(32'h0002_8000, 32'h0001_0000, 16'd6, MODE_MIRROR, 16'd0);
    send_fields(32'hFFFE_A000, 32'h0001_0000, 16'd6, MODE_MIRROR, 16'd0);
    send_fields(32'h7FFF_FFFF, 32'hFFFF_FFFF, 16'd8, MODE_WRAP, 16'd0);
    send_fields(32'h8000_0000, 32'hFFFF_FFFF, 16'd8, MODE_MIRROR, 16'd0);
    send_fields(32'h7FFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, MODE_CLAMP, 16'hFFFF);
    send_fields(32'h0000_C3A1, 32'h0001_0000, 16'hFFFF, MODE_WRAP, 16'hFFFF);
    send_fields(32'h0000_C3A1, 32'h0001_0000, 16'd3, MODE_WRAP, 16'd1);
    send_fields(32'hFFFF_3C5F, 32'h0001_0000, 16'd3, MODE_WRAP, 16'hFFFF);
    send_fields(32'h0000_0001, 32'h0000_0000, 16'd7, MODE_CLAMP, 16'd0);
    send_fields(32'hFFFF_FFFF, 32'h0000_0000, 16'd7, MODE_MIRROR, 16'd4);
    send_fields(32'h0000_FFFF, 32'h0000_FFFF, 16'd2, MODE_CLAMP, 16'd5);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      idle_on = (i < 300 || i >= 420);
      send_ctrl(random_ctrl());
    end
    start <= 1'b0;

    while (ledger.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    ledger.close_out();

    $display("covered %0d results: clamp %0d, wrap %0d, mirror %0d, no-update mode %0d",
             ledger.checked, ledger.mode_seen[MODE_CLAMP], ledger.mode_seen[MODE_WRAP],
             ledger.mode_seen[MODE_MIRROR], ledger.mode_seen[MODE_NONE]);
    $display("edge cases, saturating products and idle gaps included; %0d mismatches",
             ledger.mismatches);
    if (ledger.mismatches == 0)
      $display("animation_keyframe_sampler_top_test: PASS");
    else
      $display("animation_keyframe_sampler_top_test: FAIL");
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/aks_pkg.sv
hw/rtl/aks_norm.sv
hw/rtl/aks_frame.sv
hw/rtl/aks_div.sv
hw/rtl/animation_keyframe_sampler_top.sv
bench/animation_keyframe_sampler_top_test.sv
